/* design/suis_pkg.sv */
// shared types and constants for the sorted unique id set
package suis_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ID_W     = 32;
    localparam int COUNT_W  = 7;
    localparam int POS_W    = 6;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [2:0] {
        RES_ADDED   = 3'd0,
        RES_PRESENT = 3'd1,
        RES_REMOVED = 3'd2,
        RES_ABSENT  = 3'd3,
        RES_FULL    = 3'd4
    } res_status_t;

    typedef struct packed {
        logic                   op;
        logic signed [ID_W-1:0] member_id;
    } item_t;

    typedef struct packed {
        res_status_t        status;
        logic [COUNT_W-1:0] count;
        logic [POS_W-1:0]   position;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic        start_search;
        logic        start_up;
        logic        start_down;
        logic        write_new;
        logic        inc_count;
        logic        dec_count;
        logic        load_out;
        logic        zero_pos;
        res_status_t res_status;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic busy;
        logic found;
        logic full;
        logic out_free;
        logic op_remove;
    } dp_status_t;

endpackage

/* design/suis_datapath.sv */
// datapath: entry memory, scan and shift engine, count and result registers
module suis_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  suis_pkg::item_t     s_item,
    input  suis_pkg::cmd_t      cmd,
    output suis_pkg::dp_status_t status,
    input  logic                m_ready,
    output logic                m_valid,
    output suis_pkg::result_t   m_result
);
    import suis_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_SEARCH,
        MODE_UP,
        MODE_DOWN
    } mode_t;

    logic [ID_W-1:0] entries_mem [CAPACITY];

    mode_t             mode_reg, mode_next;
    logic [CNT_W-1:0]  src_reg, src_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic              rvalid_reg, rvalid_next;
    logic [ADDR_W-1:0] rd_src_reg, rd_src_next;
    logic [ID_W-1:0]   rdata_reg;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic              found_reg, found_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    item_t             item_reg, item_next;
    result_t           out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic              rd_en;
    logic              search_hit;
    logic              wb_en;
    logic [ADDR_W-1:0] wb_addr;

    assign search_hit = rvalid_reg && ($signed(rdata_reg) >= item_reg.member_id);
    assign wb_en      = rvalid_reg && (mode_reg == MODE_UP || mode_reg == MODE_DOWN);
    assign wb_addr    = (mode_reg == MODE_UP) ? rd_src_reg + ADDR_W'(1)
                                              : rd_src_reg - ADDR_W'(1);

    always_comb begin
        mode_next   = mode_reg;
        src_next    = src_reg;
        rem_next    = rem_reg;
        rvalid_next = 1'b0;
        rd_src_next = rd_src_reg;
        pos_next    = pos_reg;
        found_next  = found_reg;
        item_next   = item_reg;
        rd_en       = 1'b0;
        if (cmd.start_search) begin
            item_next = s_item;
            mode_next = MODE_SEARCH;
            src_next  = '0;
            rem_next  = count_reg;
        end else if (cmd.start_up) begin
            // move from the top down so nothing is overwritten early
            mode_next = MODE_UP;
            src_next  = count_reg - CNT_W'(1);
            rem_next  = count_reg - pos_reg;
        end else if (cmd.start_down) begin
            mode_next = MODE_DOWN;
            src_next  = pos_reg + CNT_W'(1);
            rem_next  = count_reg - pos_reg - CNT_W'(1);
        end else if (mode_reg != MODE_IDLE) begin
            if (mode_reg == MODE_SEARCH && search_hit) begin
                mode_next  = MODE_IDLE;
                pos_next   = CNT_W'(rd_src_reg);
                found_next = (rdata_reg == item_reg.member_id);
            end else if (rem_reg == '0 && !rvalid_reg) begin
                mode_next = MODE_IDLE;
                if (mode_reg == MODE_SEARCH) begin
                    pos_next   = count_reg;
                    found_next = 1'b0;
                end
            end else if (rem_reg != '0) begin
                rd_en       = 1'b1;
                rvalid_next = 1'b1;
                rd_src_next = src_reg[ADDR_W-1:0];
                rem_next    = rem_reg - CNT_W'(1);
                src_next    = (mode_reg == MODE_UP) ? src_reg - CNT_W'(1)
                                                    : src_reg + CNT_W'(1);
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.inc_count) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.dec_count) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out) begin
            out_next.status   = cmd.res_status;
            out_next.count    = COUNT_W'(count_reg);
            out_next.position = cmd.zero_pos ? '0 : POS_W'(pos_reg);
            out_valid_next    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_IDLE;
            rvalid_reg    <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            rvalid_reg    <= rvalid_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
        src_reg    <= src_next;
        rem_reg    <= rem_next;
        rd_src_reg <= rd_src_next;
        pos_reg    <= pos_next;
        found_reg  <= found_next;
        item_reg   <= item_next;
        out_reg    <= out_next;
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wb_en) begin
            entries_mem[wb_addr] <= rdata_reg;
        end else if (cmd.write_new) begin
            entries_mem[pos_reg[ADDR_W-1:0]] <= item_reg.member_id;
        end
        if (rd_en) begin
            rdata_reg <= entries_mem[src_reg[ADDR_W-1:0]];
        end
    end

    assign status.busy      = (mode_reg != MODE_IDLE);
    assign status.found     = found_reg;
    assign status.full      = (count_reg == CNT_W'(CAPACITY));
    assign status.out_free  = !out_valid_reg || m_ready;
    assign status.op_remove = (item_reg.op == OP_REMOVE);

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    a_new_not_during_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write_new |-> !wb_en && mode_reg == MODE_IDLE)
        else $error("new entry written while shift engine active");

    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.inc_count |-> count_reg < CNT_W'(CAPACITY))
        else $error("count incremented past capacity");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.dec_count |-> count_reg != '0 && found_reg)
        else $error("count decremented without a held entry");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !out_valid_reg || m_ready)
        else $error("pending result overwritten");

endmodule

/* design/suis_ctrl.sv */
// controller: sequences search, shift when needed, and result for each word
module suis_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  suis_pkg::dp_status_t status,
    output suis_pkg::cmd_t       cmd
);
    import suis_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_SHIFT,
        S_RESULT
    } state_t;

    state_t      state_reg, state_next;
    res_status_t res_reg, res_next;
    logic        zero_reg, zero_next;

    always_comb begin
        state_next       = state_reg;
        res_next         = res_reg;
        zero_next        = zero_reg;
        s_ready          = 1'b0;
        cmd              = '0;
        cmd.res_status   = res_reg;
        cmd.zero_pos     = zero_reg;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start_search = 1'b1;
                    state_next       = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (!status.busy) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!status.op_remove) begin
                    if (status.found) begin
                        res_next   = RES_PRESENT;
                        zero_next  = 1'b0;
                        state_next = S_RESULT;
                    end else if (status.full) begin
                        res_next   = RES_FULL;
                        zero_next  = 1'b1;
                        state_next = S_RESULT;
                    end else begin
                        cmd.start_up = 1'b1;
                        state_next   = S_SHIFT;
                    end
                end else begin
                    if (status.found) begin
                        cmd.start_down = 1'b1;
                        state_next     = S_SHIFT;
                    end else begin
                        res_next   = RES_ABSENT;
                        zero_next  = 1'b1;
                        state_next = S_RESULT;
                    end
                end
            end
            S_SHIFT: begin
                if (!status.busy) begin
                    zero_next  = 1'b0;
                    state_next = S_RESULT;
                    if (!status.op_remove) begin
                        cmd.write_new = 1'b1;
                        cmd.inc_count = 1'b1;
                        res_next      = RES_ADDED;
                    end else begin
                        cmd.dec_count = 1'b1;
                        res_next      = RES_REMOVED;
                    end
                end
            end
            S_RESULT: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            res_reg   <= RES_ADDED;
            zero_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            res_reg   <= res_next;
            zero_reg  <= zero_next;
        end
    end

    a_accept_only_when_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !status.busy)
        else $error("word accepted while engine busy");

    a_shift_follows_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.start_up || cmd.start_down) |=> state_reg == S_SHIFT && status.busy)
        else $error("shift engine did not start");

endmodule

/* design/sorted_unique_id_set.sv */
// sorted unique id set: top level joining controller and datapath
// search and shift: the scan stops at the first id not below the word's id and the shift
//   only moves the entries past it, so together they cover the set once
// throughput: one word at a time; the next word is taken once the result is registered,
//   and a result stalled by m_ready holds the controller's next result step until it frees
// reset: aresetn synchronous active low clears count, engine and handshake state;
//   entry memory is not cleared, entries at or beyond count are never read
module sorted_unique_id_set (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  suis_pkg::item_t    s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output suis_pkg::result_t  m_result
);
    import suis_pkg::*;

    // command and status between controller and datapath
    cmd_t       cmd;
    dp_status_t dp_status;

    // controller: one word in flight, search then shift when needed then result
    suis_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (dp_status),
        .cmd     (cmd)
    );

    // datapath: memory, scan/shift engine, output register
    suis_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_item   (s_item),
        .cmd      (cmd),
        .status   (dp_status),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .m_result (m_result)
    );

endmodule
